// ===== rtl/core/epw_pkg.sv =====
// Shared types and constants for the ellipse perimeter walker.
// No dependencies; used by ellipse_perimeter_walker.
package epw_pkg;

    localparam int HALF_W  = 10;
    localparam int COORD_W = 11;
    localparam int SQ_W    = 20;
    localparam int DEN_W   = 21;
    localparam int MCAND_W = 30;
    localparam int PROD_W  = 40;
    localparam int CNT_W   = 5;

    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(HALF_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(SQ_W - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQ_W / 2 - 1);

    localparam logic CFG_HALF_WIDTH  = 1'b0;
    localparam logic CFG_HALF_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POINT,
        ST_SQ1,
        ST_SQ2,
        ST_PREP,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        JOB_BX,
        JOB_BY,
        JOB_ARC
    } job_t;

    typedef enum logic [2:0] {
        SEG_TOP,
        SEG_ARC1,
        SEG_ARC2,
        SEG_ARC3,
        SEG_ARC4,
        SEG_ARC5,
        SEG_DONE
    } seg_t;

endpackage

// ===== rtl/core/ellipse_perimeter_walker.sv =====
// Ellipse perimeter walker: one perimeter point per request, clockwise from the top.
// Serial multiply, restoring divide and square root share one sequencer; uses epw_pkg.
// Top point, points past the half size and idle results skip the arithmetic; an arc point
// runs square, multiply, divide and root; a restart first computes the two breakpoints.
// One request at a time: in_stall is high from accept until ST_OUT hands the result on.
// Reset: no walk active, half sizes 1, request and config channels ready at once.
module ellipse_perimeter_walker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               restart,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [epw_pkg::COORD_W-1:0] step_x,
    output logic signed [epw_pkg::COORD_W-1:0] step_y,
    output logic signed [epw_pkg::COORD_W-1:0] offset_x,
    output logic signed [epw_pkg::COORD_W-1:0] offset_y,
    output logic                               last_point,
    output logic                               idle,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [epw_pkg::HALF_W-1:0]         cfg_data
);

    epw_pkg::state_t state_reg, state_next;
    epw_pkg::job_t   job_reg, job_next;
    epw_pkg::seg_t   segment_reg, segment_next;
    logic [epw_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    logic signed [epw_pkg::COORD_W-1:0] coord_reg, coord_next;
    logic signed [epw_pkg::COORD_W-1:0] prev_x_reg, prev_x_next;
    logic signed [epw_pkg::COORD_W-1:0] prev_y_reg, prev_y_next;
    logic [epw_pkg::HALF_W-1:0] break_x_reg, break_x_next;
    logic [epw_pkg::HALF_W-1:0] break_y_reg, break_y_next;
    logic [epw_pkg::HALF_W-1:0] half_width_reg, half_width_next;
    logic [epw_pkg::HALF_W-1:0] half_height_reg, half_height_next;
    logic                       out_valid_reg, out_valid_next;

    logic [epw_pkg::PROD_W-1:0]  p_reg, p_next;
    logic [epw_pkg::MCAND_W-1:0] mcand_reg, mcand_next;
    logic [epw_pkg::HALF_W-1:0]  mplier_reg, mplier_next;
    logic [epw_pkg::SQ_W-1:0]    sq1_reg, sq1_next;
    logic [epw_pkg::SQ_W-1:0]    sq2_reg, sq2_next;
    logic [epw_pkg::DEN_W-1:0]   den_reg, den_next;
    logic [epw_pkg::DEN_W-1:0]   rem_reg, rem_next;
    logic [epw_pkg::SQ_W-1:0]    q_reg, q_next;
    logic [epw_pkg::HALF_W-1:0]  root_reg, root_next;
    logic [epw_pkg::HALF_W-1:0]  arc_reg, arc_next;

    logic signed [epw_pkg::COORD_W-1:0] step_x_reg, step_x_next;
    logic signed [epw_pkg::COORD_W-1:0] step_y_reg, step_y_next;
    logic signed [epw_pkg::COORD_W-1:0] offset_x_reg, offset_x_next;
    logic signed [epw_pkg::COORD_W-1:0] offset_y_reg, offset_y_next;
    logic                               last_reg, last_next;
    logic                               idle_reg, idle_next;

    logic [epw_pkg::HALF_W-1:0]  hx_eff, hy_eff;
    logic [epw_pkg::HALF_W-1:0]  arc_a, arc_b, arc_t;
    logic [epw_pkg::COORD_W-1:0] coord_abs;
    logic                        arc_skip;
    logic                        cnt_zero;
    logic                        out_free;
    logic [epw_pkg::HALF_W-1:0]  sq2_op;
    logic [epw_pkg::HALF_W-1:0]  mplier_sel;

    logic [epw_pkg::MCAND_W:0]   mul_sum;
    logic [epw_pkg::PROD_W-1:0]  mul_p;

    logic [epw_pkg::DEN_W:0]     div_t;
    logic [epw_pkg::DEN_W:0]     div_diff;
    logic                        div_ge;
    logic [epw_pkg::DEN_W-1:0]   div_rem;
    logic [epw_pkg::SQ_W-1:0]    div_q;

    logic [12:0]                 sq_r;
    logic [12:0]                 sq_trial;
    logic [12:0]                 sq_diff;
    logic                        sq_ge;
    logic [12:0]                 sq_rem;
    logic [epw_pkg::HALF_W-1:0]  sq_root;

    logic signed [epw_pkg::COORD_W-1:0] bx11, by11, arc11, px, py, pt_coord;
    epw_pkg::seg_t                      pt_seg;

    assign hx_eff = (half_width_reg == '0) ? epw_pkg::HALF_W'(1) : half_width_reg;
    assign hy_eff = (half_height_reg == '0) ? epw_pkg::HALF_W'(1) : half_height_reg;

    assign arc_a = (segment_reg == epw_pkg::SEG_ARC2 || segment_reg == epw_pkg::SEG_ARC4)
                   ? hy_eff : hx_eff;
    assign arc_b = (segment_reg == epw_pkg::SEG_ARC2 || segment_reg == epw_pkg::SEG_ARC4)
                   ? hx_eff : hy_eff;
    assign coord_abs = coord_reg[epw_pkg::COORD_W-1] ? (-coord_reg) : coord_reg;
    assign arc_t     = coord_abs[epw_pkg::HALF_W-1:0];
    assign arc_skip  = (segment_reg == epw_pkg::SEG_DONE) || (segment_reg == epw_pkg::SEG_TOP)
                       || (coord_abs >= {1'b0, arc_a});

    assign cnt_zero = (cnt_reg == '0);
    assign out_free = !out_valid_reg || !out_stall;
    assign sq2_op   = (job_reg == epw_pkg::JOB_ARC) ? arc_t : hy_eff;
    assign mplier_sel = (job_reg == epw_pkg::JOB_BX) ? hx_eff :
                        (job_reg == epw_pkg::JOB_BY) ? hy_eff : arc_b;

    // LSB-first shift-add multiply, one multiplier bit per cycle
    assign mul_sum = {1'b0, p_reg[epw_pkg::PROD_W-1:epw_pkg::HALF_W]}
                     + (p_reg[0] ? {1'b0, mcand_reg} : '0);
    assign mul_p   = {mul_sum, p_reg[epw_pkg::HALF_W-1:1]};

    // restoring divide, one quotient bit per cycle
    assign div_t    = {rem_reg, q_reg[epw_pkg::SQ_W-1]};
    assign div_diff = div_t - {1'b0, den_reg};
    assign div_ge   = (div_t >= {1'b0, den_reg});
    assign div_rem  = div_ge ? div_diff[epw_pkg::DEN_W-1:0] : div_t[epw_pkg::DEN_W-1:0];
    assign div_q    = {q_reg[epw_pkg::SQ_W-2:0], div_ge};

    // square root, one root bit per cycle
    assign sq_r     = {rem_reg[10:0], q_reg[epw_pkg::SQ_W-1:epw_pkg::SQ_W-2]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_ge    = (sq_r >= sq_trial);
    assign sq_diff  = sq_r - sq_trial;
    assign sq_rem   = sq_ge ? sq_diff : sq_r;
    assign sq_root  = {root_reg[epw_pkg::HALF_W-2:0], sq_ge};

    assign bx11  = signed'({1'b0, break_x_reg});
    assign by11  = signed'({1'b0, break_y_reg});
    assign arc11 = signed'({1'b0, arc_reg});

    always_comb
    begin
        px       = '0;
        py       = '0;
        pt_seg   = segment_reg;
        pt_coord = coord_reg;
        unique case (segment_reg)
            epw_pkg::SEG_TOP:
            begin
                py = -signed'({1'b0, hy_eff});
                if (break_x_reg != '0)
                begin
                    pt_seg   = epw_pkg::SEG_ARC1;
                    pt_coord = 11'sd1;
                end
                else
                begin
                    pt_seg   = epw_pkg::SEG_ARC2;
                    pt_coord = -by11;
                end
            end
            epw_pkg::SEG_ARC1:
            begin
                px = coord_reg;
                py = -arc11;
                if (coord_reg < bx11)
                begin
                    pt_coord = coord_reg + 11'sd1;
                end
                else
                begin
                    pt_seg   = epw_pkg::SEG_ARC2;
                    pt_coord = -by11;
                end
            end
            epw_pkg::SEG_ARC2:
            begin
                px = arc11;
                py = coord_reg;
                if (coord_reg < by11)
                begin
                    pt_coord = coord_reg + 11'sd1;
                end
                else
                begin
                    pt_seg   = epw_pkg::SEG_ARC3;
                    pt_coord = bx11;
                end
            end
            epw_pkg::SEG_ARC3:
            begin
                px = coord_reg;
                py = arc11;
                if (coord_reg > -bx11)
                begin
                    pt_coord = coord_reg - 11'sd1;
                end
                else
                begin
                    pt_seg   = epw_pkg::SEG_ARC4;
                    pt_coord = by11;
                end
            end
            epw_pkg::SEG_ARC4:
            begin
                px = -arc11;
                py = coord_reg;
                if (coord_reg > -by11)
                begin
                    pt_coord = coord_reg - 11'sd1;
                end
                else if (break_x_reg != '0)
                begin
                    pt_seg   = epw_pkg::SEG_ARC5;
                    pt_coord = -bx11;
                end
                else
                begin
                    pt_seg   = epw_pkg::SEG_DONE;
                    pt_coord = '0;
                end
            end
            epw_pkg::SEG_ARC5:
            begin
                px = coord_reg;
                py = -arc11;
                if (coord_reg < -11'sd1)
                begin
                    pt_coord = coord_reg + 11'sd1;
                end
                else
                begin
                    pt_seg   = epw_pkg::SEG_DONE;
                    pt_coord = '0;
                end
            end
            default:
            begin
                pt_seg   = segment_reg;
                pt_coord = coord_reg;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            epw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = restart ? epw_pkg::ST_SQ1 : epw_pkg::ST_POINT;
                end
            end
            epw_pkg::ST_POINT:
            begin
                state_next = arc_skip ? epw_pkg::ST_OUT : epw_pkg::ST_SQ1;
            end
            epw_pkg::ST_SQ1:
            begin
                if (cnt_zero)
                begin
                    state_next = epw_pkg::ST_SQ2;
                end
            end
            epw_pkg::ST_SQ2:
            begin
                if (cnt_zero)
                begin
                    state_next = epw_pkg::ST_PREP;
                end
            end
            epw_pkg::ST_PREP:
            begin
                state_next = epw_pkg::ST_MUL1;
            end
            epw_pkg::ST_MUL1:
            begin
                if (cnt_zero)
                begin
                    state_next = epw_pkg::ST_MUL2;
                end
            end
            epw_pkg::ST_MUL2:
            begin
                if (cnt_zero)
                begin
                    state_next = epw_pkg::ST_DIV;
                end
            end
            epw_pkg::ST_DIV:
            begin
                if (cnt_zero)
                begin
                    state_next = epw_pkg::ST_SQRT;
                end
            end
            epw_pkg::ST_SQRT:
            begin
                if (cnt_zero)
                begin
                    priority if (job_reg == epw_pkg::JOB_BX)
                    begin
                        state_next = epw_pkg::ST_PREP;
                    end
                    else if (job_reg == epw_pkg::JOB_BY)
                    begin
                        state_next = epw_pkg::ST_POINT;
                    end
                    else
                    begin
                        state_next = epw_pkg::ST_OUT;
                    end
                end
            end
            epw_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = epw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = epw_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        job_next         = job_reg;
        segment_next     = segment_reg;
        cnt_next         = cnt_reg;
        coord_next       = coord_reg;
        prev_x_next      = prev_x_reg;
        prev_y_next      = prev_y_reg;
        break_x_next     = break_x_reg;
        break_y_next     = break_y_reg;
        half_width_next  = half_width_reg;
        half_height_next = half_height_reg;
        out_valid_next   = out_valid_reg && out_stall;
        p_next           = p_reg;
        mcand_next       = mcand_reg;
        mplier_next      = mplier_reg;
        sq1_next         = sq1_reg;
        sq2_next         = sq2_reg;
        den_next         = den_reg;
        rem_next         = rem_reg;
        q_next           = q_reg;
        root_next        = root_reg;
        arc_next         = arc_reg;
        step_x_next      = step_x_reg;
        step_y_next      = step_y_reg;
        offset_x_next    = offset_x_reg;
        offset_y_next    = offset_y_reg;
        last_next        = last_reg;
        idle_next        = idle_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                epw_pkg::CFG_HALF_WIDTH:  half_width_next  = cfg_data;
                epw_pkg::CFG_HALF_HEIGHT: half_height_next = cfg_data;
            endcase
        end

        unique case (state_reg)
            epw_pkg::ST_IDLE:
            begin
                if (in_valid && restart)
                begin
                    job_next   = epw_pkg::JOB_BX;
                    p_next     = {{(epw_pkg::PROD_W-epw_pkg::HALF_W){1'b0}}, hx_eff};
                    mcand_next = {{(epw_pkg::MCAND_W-epw_pkg::HALF_W){1'b0}}, hx_eff};
                    cnt_next   = epw_pkg::MUL_LAST;
                end
            end
            epw_pkg::ST_POINT:
            begin
                arc_next   = '0;
                job_next   = epw_pkg::JOB_ARC;
                p_next     = {{(epw_pkg::PROD_W-epw_pkg::HALF_W){1'b0}}, arc_a};
                mcand_next = {{(epw_pkg::MCAND_W-epw_pkg::HALF_W){1'b0}}, arc_a};
                cnt_next   = epw_pkg::MUL_LAST;
            end
            epw_pkg::ST_SQ1:
            begin
                p_next   = mul_p;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_zero)
                begin
                    sq1_next   = mul_p[epw_pkg::SQ_W-1:0];
                    p_next     = {{(epw_pkg::PROD_W-epw_pkg::HALF_W){1'b0}}, sq2_op};
                    mcand_next = {{(epw_pkg::MCAND_W-epw_pkg::HALF_W){1'b0}}, sq2_op};
                    cnt_next   = epw_pkg::MUL_LAST;
                end
            end
            epw_pkg::ST_SQ2:
            begin
                p_next   = mul_p;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_zero)
                begin
                    sq2_next = mul_p[epw_pkg::SQ_W-1:0];
                end
            end
            epw_pkg::ST_PREP:
            begin
                mplier_next = mplier_sel;
                p_next      = {{(epw_pkg::PROD_W-epw_pkg::HALF_W){1'b0}}, mplier_sel};
                cnt_next    = epw_pkg::MUL_LAST;
                priority if (job_reg == epw_pkg::JOB_BX)
                begin
                    den_next   = {1'b0, sq1_reg} + {1'b0, sq2_reg};
                    mcand_next = {{(epw_pkg::MCAND_W-epw_pkg::SQ_W){1'b0}}, sq1_reg};
                end
                else if (job_reg == epw_pkg::JOB_BY)
                begin
                    den_next   = {1'b0, sq1_reg} + {1'b0, sq2_reg};
                    mcand_next = {{(epw_pkg::MCAND_W-epw_pkg::SQ_W){1'b0}}, sq2_reg};
                end
                else
                begin
                    den_next   = {1'b0, sq1_reg};
                    mcand_next = {{(epw_pkg::MCAND_W-epw_pkg::SQ_W){1'b0}}, sq1_reg - sq2_reg};
                end
            end
            epw_pkg::ST_MUL1:
            begin
                p_next   = mul_p;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_zero)
                begin
                    mcand_next = mul_p[epw_pkg::MCAND_W-1:0];
                    p_next     = {{(epw_pkg::PROD_W-epw_pkg::HALF_W){1'b0}}, mplier_reg};
                    cnt_next   = epw_pkg::MUL_LAST;
                end
            end
            epw_pkg::ST_MUL2:
            begin
                p_next   = mul_p;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_zero)
                begin
                    rem_next = {1'b0, mul_p[epw_pkg::PROD_W-1:epw_pkg::SQ_W]};
                    q_next   = mul_p[epw_pkg::SQ_W-1:0];
                    cnt_next = epw_pkg::DIV_LAST;
                end
            end
            epw_pkg::ST_DIV:
            begin
                rem_next = div_rem;
                q_next   = div_q;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_zero)
                begin
                    rem_next  = '0;
                    root_next = '0;
                    cnt_next  = epw_pkg::SQRT_LAST;
                end
            end
            epw_pkg::ST_SQRT:
            begin
                rem_next  = {{(epw_pkg::DEN_W-13){1'b0}}, sq_rem};
                q_next    = {q_reg[epw_pkg::SQ_W-3:0], 2'b00};
                root_next = sq_root;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_zero)
                begin
                    priority if (job_reg == epw_pkg::JOB_BX)
                    begin
                        break_x_next = sq_root;
                        job_next     = epw_pkg::JOB_BY;
                    end
                    else if (job_reg == epw_pkg::JOB_BY)
                    begin
                        break_y_next = sq_root;
                        segment_next = epw_pkg::SEG_TOP;
                        coord_next   = '0;
                        prev_x_next  = '0;
                        prev_y_next  = '0;
                    end
                    else
                    begin
                        arc_next = sq_root;
                    end
                end
            end
            epw_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (segment_reg == epw_pkg::SEG_DONE)
                    begin
                        step_x_next   = '0;
                        step_y_next   = '0;
                        offset_x_next = '0;
                        offset_y_next = '0;
                        last_next     = 1'b0;
                        idle_next     = 1'b1;
                    end
                    else
                    begin
                        step_x_next   = px - prev_x_reg;
                        step_y_next   = py - prev_y_reg;
                        offset_x_next = px;
                        offset_y_next = py;
                        last_next     = (pt_seg == epw_pkg::SEG_DONE);
                        idle_next     = 1'b0;
                        prev_x_next   = px;
                        prev_y_next   = py;
                        segment_next  = pt_seg;
                        coord_next    = pt_coord;
                    end
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= epw_pkg::ST_IDLE;
            job_reg         <= epw_pkg::JOB_ARC;
            segment_reg     <= epw_pkg::SEG_DONE;
            cnt_reg         <= '0;
            coord_reg       <= '0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            break_x_reg     <= '0;
            break_y_reg     <= '0;
            half_width_reg  <= epw_pkg::HALF_W'(1);
            half_height_reg <= epw_pkg::HALF_W'(1);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            job_reg         <= job_next;
            segment_reg     <= segment_next;
            cnt_reg         <= cnt_next;
            coord_reg       <= coord_next;
            prev_x_reg      <= prev_x_next;
            prev_y_reg      <= prev_y_next;
            break_x_reg     <= break_x_next;
            break_y_reg     <= break_y_next;
            half_width_reg  <= half_width_next;
            half_height_reg <= half_height_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        sq1_reg      <= sq1_next;
        sq2_reg      <= sq2_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        root_reg     <= root_next;
        arc_reg      <= arc_next;
        step_x_reg   <= step_x_next;
        step_y_reg   <= step_y_next;
        offset_x_reg <= offset_x_next;
        offset_y_reg <= offset_y_next;
        last_reg     <= last_next;
        idle_reg     <= idle_next;
    end

    assign in_stall   = (state_reg != epw_pkg::ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign step_x     = step_x_reg;
    assign step_y     = step_y_reg;
    assign offset_x   = offset_x_reg;
    assign offset_y   = offset_y_reg;
    assign last_point = last_reg;
    assign idle       = idle_reg;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for ellipse_perimeter_walker: directed table, then random walks.
// Expected points come from typed table rows or an in-bench walk predictor; depends on epw_pkg and the RTL.
// Both channels idle and stall at random, and registers change between phases.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_REQS   = 2000;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int SMALL_MAX   = 24;

    typedef struct packed {
        logic signed [epw_pkg::COORD_W-1:0] step_x;
        logic signed [epw_pkg::COORD_W-1:0] step_y;
        logic signed [epw_pkg::COORD_W-1:0] offset_x;
        logic signed [epw_pkg::COORD_W-1:0] offset_y;
        logic                               last_point;
        logic                               idle;
    } point_t;

    typedef struct {
        bit                         cfg;
        logic                       idx;
        logic [epw_pkg::HALF_W-1:0] val;
        bit                         rs;
        bit                         typed;
        point_t                     want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic restart = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [epw_pkg::COORD_W-1:0] step_x, step_y, offset_x, offset_y;
    logic last_point, idle;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = epw_pkg::CFG_HALF_WIDTH;
    logic [epw_pkg::HALF_W-1:0] cfg_data = '0;

    ellipse_perimeter_walker uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .step_x    (step_x),
        .step_y    (step_y),
        .offset_x  (offset_x),
        .offset_y  (offset_y),
        .last_point(last_point),
        .idle      (idle),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // walk predictor state
    logic [epw_pkg::HALF_W-1:0] reg_hw = 10'd1;
    logic [epw_pkg::HALF_W-1:0] reg_hh = 10'd1;
    epw_pkg::seg_t cur_seg = epw_pkg::SEG_DONE;
    int cur_coord = 0;
    int last_x = 0;
    int last_y = 0;
    int brk_x = 0;
    int brk_y = 0;

    point_t pending_points[$];
    point_t got_want;

    int n_err = 0;
    int n_req = 0;
    int n_restart = 0;
    int n_cfg = 0;
    int n_last = 0;
    int n_idle = 0;
    int cycles = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;
    int stall_mode = 0;
    int stall_left = 0;
    int mode_left = 0;

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'h1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end
            else
                r >>= 1;
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic int eff_size(logic [epw_pkg::HALF_W-1:0] v);
        return (v == 0) ? 1 : int'(v);
    endfunction

    // b * sqrt(1 - (t/a)^2), truncated; zero once |t| reaches a
    function automatic int arc_len(int a, int b, int t);
        longint unsigned at, al, bl;
        at = (t < 0) ? -t : t;
        al = a;
        bl = b;
        if (at >= al)
            return 0;
        return int'(root64((bl * bl * (al * al - at * at)) / (al * al)));
    endfunction

    function automatic point_t next_point(bit rs);
        int hx, hy, px, py, c;
        longint unsigned hx2, hy2, sum;
        epw_pkg::seg_t nxt;
        point_t p;
        hx = eff_size(reg_hw);
        hy = eff_size(reg_hh);
        px = 0;
        py = 0;
        p = '0;
        if (rs) begin
            hx2 = hx * hx;
            hy2 = hy * hy;
            sum = hx2 + hy2;
            brk_x = int'(root64((hx2 * hx2) / sum));
            brk_y = int'(root64((hy2 * hy2) / sum));
            cur_seg = epw_pkg::SEG_TOP;
            cur_coord = 0;
            last_x = 0;
            last_y = 0;
        end
        if (cur_seg == epw_pkg::SEG_DONE) begin
            p.idle = 1'b1;
            return p;
        end
        c = cur_coord;
        nxt = cur_seg;
        case (cur_seg)
            epw_pkg::SEG_TOP: begin
                py = -hy;
                if (brk_x >= 1) begin
                    nxt = epw_pkg::SEG_ARC1;
                    c = 1;
                end
                else begin
                    nxt = epw_pkg::SEG_ARC2;
                    c = -brk_y;
                end
            end
            epw_pkg::SEG_ARC1: begin
                px = c;
                py = -arc_len(hx, hy, c);
                if (c < brk_x)
                    c++;
                else begin
                    nxt = epw_pkg::SEG_ARC2;
                    c = -brk_y;
                end
            end
            epw_pkg::SEG_ARC2: begin
                py = c;
                px = arc_len(hy, hx, c);
                if (c < brk_y)
                    c++;
                else begin
                    nxt = epw_pkg::SEG_ARC3;
                    c = brk_x;
                end
            end
            epw_pkg::SEG_ARC3: begin
                px = c;
                py = arc_len(hx, hy, c);
                if (c > -brk_x)
                    c--;
                else begin
                    nxt = epw_pkg::SEG_ARC4;
                    c = brk_y;
                end
            end
            epw_pkg::SEG_ARC4: begin
                py = c;
                px = -arc_len(hy, hx, c);
                if (c > -brk_y)
                    c--;
                else if (brk_x >= 1) begin
                    nxt = epw_pkg::SEG_ARC5;
                    c = -brk_x;
                end
                else begin
                    nxt = epw_pkg::SEG_DONE;
                    c = 0;
                end
            end
            default: begin
                px = c;
                py = -arc_len(hx, hy, c);
                if (c < -1)
                    c++;
                else begin
                    nxt = epw_pkg::SEG_DONE;
                    c = 0;
                end
            end
        endcase
        p.step_x = epw_pkg::COORD_W'(px - last_x);
        p.step_y = epw_pkg::COORD_W'(py - last_y);
        p.offset_x = epw_pkg::COORD_W'(px);
        p.offset_y = epw_pkg::COORD_W'(py);
        p.last_point = (nxt == epw_pkg::SEG_DONE);
        last_x = px;
        last_y = py;
        cur_seg = nxt;
        cur_coord = c;
        return p;
    endfunction

    task automatic send_req(input bit rs, input bit typed, input point_t want,
                            output point_t p);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        restart <= rs;
        do
            @(posedge clk);
        while (in_stall);
        p = next_point(rs);
        pending_points.push_back(typed ? want : p);
        n_req++;
        if (rs)
            n_restart++;
    endtask

    // hold the request channel until every point is back
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [epw_pkg::HALF_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == epw_pkg::CFG_HALF_WIDTH)
            reg_hw = v;
        else
            reg_hh = v;
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [epw_pkg::HALF_W-1:0] pick_size(bit big);
        if (!big)
            return epw_pkg::HALF_W'($urandom_range(0, SMALL_MAX));
        if ($urandom_range(0, 3) == 0)
            return 10'd1023;
        return epw_pkg::HALF_W'($urandom_range(SMALL_MAX + 1, 1023));
    endfunction

    always @(negedge clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(100, 600);
        end
        else
            mode_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    out_stall <= 1'b1;
                end
                else begin
                    out_stall <= 1'b0;
                    if ($urandom_range(0, 9) == 0)
                        stall_left = $urandom_range(1, 20);
                end
            end
        endcase
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_points.size() == 0) begin
                $error("point with no request outstanding");
                n_err++;
            end
            else begin
                got_want = pending_points.pop_front();
                if (step_x !== got_want.step_x) begin
                    $error("step_x expected %0d got %0d", got_want.step_x, step_x);
                    n_err++;
                end
                if (step_y !== got_want.step_y) begin
                    $error("step_y expected %0d got %0d", got_want.step_y, step_y);
                    n_err++;
                end
                if (offset_x !== got_want.offset_x) begin
                    $error("offset_x expected %0d got %0d", got_want.offset_x, offset_x);
                    n_err++;
                end
                if (offset_y !== got_want.offset_y) begin
                    $error("offset_y expected %0d got %0d", got_want.offset_y, offset_y);
                    n_err++;
                end
                if (last_point !== got_want.last_point) begin
                    $error("last_point expected %0d got %0d", got_want.last_point,
                           last_point);
                    n_err++;
                end
                if (idle !== got_want.idle) begin
                    $error("idle expected %0d got %0d", got_want.idle, idle);
                    n_err++;
                end
                if (last_point === 1'b1)
                    n_last++;
                if (idle === 1'b1)
                    n_idle++;
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d points outstanding", cycles,
                   pending_points.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // directed: idle, unit ellipse walk, extremes, zero size, resize and restart mid-walk,
    // then a full walk that uses all five arc segments
    plan_row_t dir_plan [31] = '{
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 0, 1, '{0, 0, 0, 0, 0, 1}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 1, 1, '{0, -1, 0, -1, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 0, 1, '{1, 1, 1, 0, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 0, 1, '{-1, 1, 0, 1, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 0, 1, '{-1, -1, -1, 0, 1, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 0, 1, '{0, 0, 0, 0, 0, 1}},
        '{1, epw_pkg::CFG_HALF_WIDTH, 1023, 0, 0, '{0, 0, 0, 0, 0, 0}},
        '{1, epw_pkg::CFG_HALF_HEIGHT, 1023, 0, 0, '{0, 0, 0, 0, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 1, 1, '{0, -1023, 0, -1023, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 0, 0, '{0, 0, 0, 0, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 0, 0, '{0, 0, 0, 0, 0, 0}},
        '{1, epw_pkg::CFG_HALF_WIDTH, 0, 0, 0, '{0, 0, 0, 0, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 0, 0, '{0, 0, 0, 0, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 0, 0, '{0, 0, 0, 0, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 1, 0, '{0, 0, 0, 0, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 0, 0, '{0, 0, 0, 0, 0, 0}},
        '{1, epw_pkg::CFG_HALF_WIDTH, 3, 0, 0, '{0, 0, 0, 0, 0, 0}},
        '{1, epw_pkg::CFG_HALF_HEIGHT, 1, 0, 0, '{0, 0, 0, 0, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 1, 0, '{0, 0, 0, 0, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 0, 0, '{0, 0, 0, 0, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 0, 0, '{0, 0, 0, 0, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 0, 0, '{0, 0, 0, 0, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 0, 0, '{0, 0, 0, 0, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 0, 0, '{0, 0, 0, 0, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 0, 0, '{0, 0, 0, 0, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 0, 0, '{0, 0, 0, 0, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 0, 0, '{0, 0, 0, 0, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 0, 0, '{0, 0, 0, 0, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 0, 0, '{0, 0, 0, 0, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 0, 0, '{0, 0, 0, 0, 0, 0}},
        '{0, epw_pkg::CFG_HALF_WIDTH, 0, 0, 1, '{0, 0, 0, 0, 0, 1}}
    };

    initial begin
        point_t p;
        int start_req, kind, sel, mode;
        bit big, small_walk;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_plan[i]) begin
            if (dir_plan[i].cfg) begin
                settle();
                write_reg(dir_plan[i].idx, dir_plan[i].val);
            end
            else
                send_req(dir_plan[i].rs, dir_plan[i].typed, dir_plan[i].want, p);
        end

        start_req = n_req;
        while (n_req - start_req < RAND_REQS) begin
            settle();
            kind = $urandom_range(0, 99);
            big = ($urandom_range(0, 5) == 0);
            if (kind < 80) begin
                sel = $urandom_range(0, 3);
                if (sel != 2)
                    write_reg(epw_pkg::CFG_HALF_WIDTH, pick_size(big));
                if (sel != 1)
                    write_reg(epw_pkg::CFG_HALF_HEIGHT, pick_size(big && sel != 0));
            end
            gaps_on = ($urandom_range(0, 3) != 0);
            burst_left = 0;
            small_walk = (reg_hw <= SMALL_MAX) && (reg_hh <= SMALL_MAX);
            mode = $urandom_range(0, 9);
            if (mode < 6 && small_walk) begin
                repeat ($urandom_range(1, 3)) begin
                    send_req(1'b1, 1'b0, '0, p);
                    while (!p.last_point)
                        send_req(1'b0, 1'b0, '0, p);
                    repeat ($urandom_range(0, 2))
                        send_req(1'b0, 1'b0, '0, p);
                end
            end
            else if (mode < 8) begin
                send_req(1'b1, 1'b0, '0, p);
                repeat ($urandom_range(3, 40))
                    send_req(1'b0, 1'b0, '0, p);
            end
            else if (mode == 8) begin
                // carry on with whatever walk is in progress under the new sizes
                repeat ($urandom_range(3, 40))
                    send_req(1'b0, 1'b0, '0, p);
            end
            else begin
                repeat ($urandom_range(5, 30))
                    send_req($urandom_range(0, 7) == 0, 1'b0, '0, p);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        $display("Covered %0d requests (%0d restarts) over %0d register writes.",
                 n_req, n_restart, n_cfg);
        $display("Saw %0d finished walks and %0d idle answers; %0d mismatches.",
                 n_last, n_idle, n_err);
        if (n_err == 0 && pending_points.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
